>>> rtl/chi_pkg.sv
// Package for the chained hash index: sizes, status codes and the node record.
// Used by the channel interfaces and by the top level chained_hash_index_unit.
package chi_pkg;

  localparam int unsigned BUCKETS       = 1024;
  localparam int unsigned ENTRIES       = 4096;
  localparam int unsigned LOCATION_BITS = 32;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned NODE_AW = $clog2(ENTRIES);
  localparam int unsigned LINK_W  = NODE_AW + 1;
  localparam int unsigned STAT_W  = 3;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [LINK_W-1:0]        link;
    logic [LOCATION_BITS-1:0] loc;
  } node_t;

endpackage

>>> rtl/chi_req_if.sv
// Request channel of the chained hash index: opcode, key and location.
// Depends on chi_pkg for field widths.
interface chi_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [chi_pkg::KEY_W-1:0]  key;
  logic [31:0]                       location;

  modport source (output valid, output opcode, output key, output location, input ready);
  modport sink   (input valid, input opcode, input key, input location, output ready);
endinterface

>>> rtl/chi_rsp_if.sv
// Response channel of the chained hash index: status and found location.
// Depends on chi_pkg for field widths.
interface chi_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [chi_pkg::STAT_W-1:0]    status;
  logic [31:0]                   found_location;

  modport source (output valid, output status, output found_location, input ready);
  modport sink   (input valid, input status, input found_location, output ready);
endinterface

>>> rtl/chained_hash_index_unit.sv
// Top level of the chained hash index: bucket head memory, node memory and sequencer.
// Depends on chi_pkg, chi_req_if and chi_rsp_if.
//
// Maps signed 32-bit keys to location words with separate chaining. An item
// is accepted, the bucket remainder of its key magnitude is formed bit-serially,
// the bucket head is read and checked, the chain nodes are visited one by one,
// and the result is committed and presented. The next item is accepted only
// once the result has moved to the output, which waits while the previous
// result is still waiting to be taken. How far the node memory walk goes
// depends on the chain. After reset a clearing pass empties the bucket heads;
// no item is accepted meanwhile, configuration writes are taken.
module chained_hash_index_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [chi_pkg::CNT_W-1:0] cfg_wdata_i,
  chi_req_if.sink                req_i,
  chi_rsp_if.source              rsp_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_HRD  = 3'd3;
  localparam logic [2:0] S_HCHK = 3'd4;
  localparam logic [2:0] S_NCHK = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int unsigned LW = chi_pkg::LINK_W;
  localparam int unsigned AW = chi_pkg::NODE_AW;
  localparam int unsigned BW = chi_pkg::BKT_W;
  localparam int unsigned CW = chi_pkg::CNT_W;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] bc_q;
  logic [BW-1:0] clr_q;
  logic [4:0]    bit_q;
  logic [31:0]   mag_q;
  logic [CW-1:0] rem_q;
  logic          op_q;
  logic [31:0]   key_q;
  logic [31:0]   loc_q;
  logic [LW-1:0] head_val_q;
  logic [LW-1:0] cur_q;
  logic          found_q;
  logic [LW-1:0] hit_link_q;
  logic [31:0]   hit_loc_q;
  logic [LW-1:0] used_q;
  logic [chi_pkg::STAT_W-1:0] res_status_q;
  logic [31:0]   res_loc_q;
  logic          out_valid_q;
  logic [chi_pkg::STAT_W-1:0] out_status_q;
  logic [31:0]   out_loc_q;

  // Bucket head memory.
  logic [LW-1:0] heads [chi_pkg::BUCKETS];
  logic [LW-1:0] head_rd_q;
  logic          head_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;

  // Node memory holding key, link and location per pool node.
  chi_pkg::node_t nodes [chi_pkg::ENTRIES];
  chi_pkg::node_t node_rd_q;
  logic           node_we;
  logic [AW-1:0]  node_waddr;
  chi_pkg::node_t node_wdata;
  logic [AW-1:0]  node_raddr;

  logic [CW:0]   trial;
  logic          new_ok;
  logic [CW-1:0] cfg_clamped;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_clamped = CW'(1);
    end else if (cfg_wdata_i > CW'(chi_pkg::BUCKETS)) begin
      cfg_clamped = CW'(chi_pkg::BUCKETS);
    end else begin
      cfg_clamped = cfg_wdata_i;
    end
  end

  assign trial  = {rem_q, mag_q[31]};
  assign new_ok = (used_q != LW'(chi_pkg::ENTRIES));

  always_comb begin
    if (state_q == S_HCHK) begin
      node_raddr = AW'(head_rd_q - LW'(1));
    end else begin
      node_raddr = AW'(node_rd_q.link - LW'(1));
    end
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = rem_q[BW-1:0];
    head_wdata = '0;
    node_we    = 1'b0;
    node_waddr = used_q[AW-1:0];
    node_wdata = '{key: key_q, link: head_val_q, loc: loc_q};
    if (state_q == S_CLR) begin
      head_we    = 1'b1;
      head_waddr = clr_q;
    end else if (state_q == S_RES && op_q == chi_pkg::OP_INSERT) begin
      if (found_q) begin
        node_we    = 1'b1;
        node_waddr = AW'(cur_q - LW'(1));
        node_wdata = '{key: key_q, link: hit_link_q, loc: loc_q};
      end else if (new_ok) begin
        node_we    = 1'b1;
        head_we    = 1'b1;
        head_wdata = used_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      heads[head_waddr] <= head_wdata;
    end
    head_rd_q <= heads[rem_q[BW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      nodes[node_waddr] <= node_wdata;
    end
    node_rd_q <= nodes[node_raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == BW'(chi_pkg::BUCKETS - 1)) state_d = S_IDLE;
      S_IDLE: if (req_i.valid) state_d = S_DIV;
      S_DIV:  if (bit_q == '0) state_d = S_HRD;
      S_HRD:  state_d = S_HCHK;
      S_HCHK: state_d = (head_rd_q == '0) ? S_RES : S_NCHK;
      S_NCHK: begin
        if (node_rd_q.key == key_q || node_rd_q.link == '0) begin
          state_d = S_RES;
        end
      end
      S_RES:  state_d = S_OUT;
      S_OUT:  if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      bc_q        <= CW'(chi_pkg::BUCKETS);
      clr_q       <= '0;
      bit_q       <= '0;
      rem_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bc_q <= cfg_clamped;
      end
      if (state_q == S_CLR) begin
        clr_q <= clr_q + BW'(1);
      end
      if (state_q == S_IDLE && req_i.valid) begin
        bit_q <= 5'd31;
        rem_q <= '0;
      end else if (state_q == S_DIV) begin
        bit_q <= bit_q - 5'd1;
        if (trial >= {1'b0, bc_q}) begin
          rem_q <= CW'(trial - {1'b0, bc_q});
        end else begin
          rem_q <= trial[CW-1:0];
        end
      end
      if (state_q == S_RES && op_q == chi_pkg::OP_INSERT && !found_q && new_ok) begin
        used_q <= used_q + LW'(1);
      end
      if (state_q == S_OUT && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key;
      loc_q <= req_i.location;
      mag_q <= req_i.key[31] ? (~req_i.key + 32'd1) : req_i.key;
    end else if (state_q == S_DIV) begin
      mag_q <= {mag_q[30:0], 1'b0};
    end
    if (state_q == S_HCHK) begin
      head_val_q <= head_rd_q;
      cur_q      <= head_rd_q;
      found_q    <= 1'b0;
    end
    if (state_q == S_NCHK) begin
      if (node_rd_q.key == key_q) begin
        found_q    <= 1'b1;
        hit_link_q <= node_rd_q.link;
        hit_loc_q  <= node_rd_q.loc;
      end else begin
        cur_q <= node_rd_q.link;
      end
    end
    if (state_q == S_RES) begin
      res_loc_q <= (op_q == chi_pkg::OP_SEARCH && found_q) ? hit_loc_q : '0;
      if (op_q == chi_pkg::OP_SEARCH) begin
        res_status_q <= found_q ? chi_pkg::ST_HIT : chi_pkg::ST_MISS;
      end else if (found_q) begin
        res_status_q <= chi_pkg::ST_UPDATED;
      end else if (new_ok) begin
        res_status_q <= chi_pkg::ST_INSERTED;
      end else begin
        res_status_q <= chi_pkg::ST_FULL;
      end
    end
    if (state_q == S_OUT && (!out_valid_q || rsp_o.ready)) begin
      out_status_q <= res_status_q;
      out_loc_q    <= res_loc_q;
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.found_location = out_loc_q;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= LW'(chi_pkg::ENTRIES))
    else $error("pool fill count exceeds pool size");

  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q != '0 && bc_q <= CW'(chi_pkg::BUCKETS))
    else $error("bucket count out of range");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !req_i.ready)
    else $error("item accepted during head clearing");

  a_head_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_we && state_q == S_RES) |=> used_q == $past(used_q) + LW'(1))
    else $error("head linked without taking a pool node");

  a_rem_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HRD |-> rem_q < bc_q)
    else $error("bucket remainder not below bucket count");
`endif

endmodule

>>> test/chained_hash_index_unit_tb.sv
// Self-checking testbench for chained_hash_index_unit: directed, bucket count, random and pool-full tests.
// It keeps its own copy of the hash table and checks every response in order.
// Depends on chi_pkg, chi_req_if, chi_rsp_if and the RTL top level.
module chained_hash_index_unit_tb;
  import chi_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       found_location;
  } rsp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  chi_req_if req_ch ();
  chi_rsp_if rsp_ch ();

  chained_hash_index_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch.sink),
    .rsp_o       (rsp_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the index.
  int unsigned      head_of_bucket [BUCKETS];
  logic [31:0]      node_key [ENTRIES];
  logic [31:0]      node_loc [ENTRIES];
  int unsigned      node_next [ENTRIES];
  int unsigned      nodes_used;
  int unsigned      bucket_cnt;

  rsp_item_t        pending_rsp [$];
  logic [31:0]      known_keys [$];
  int unsigned      mismatches;
  int unsigned      cycle_cnt;
  int unsigned      snd_idle_pct;
  int unsigned      rcv_idle_pct;

  function automatic int unsigned find_key_node(logic [31:0] key);
    logic [31:0] mag;
    int unsigned cur;
    int unsigned steps;
    mag = key[31] ? (~key + 32'd1) : key;
    cur = head_of_bucket[mag % bucket_cnt];
    steps = 0;
    while (cur != 0 && steps < ENTRIES) begin
      if (node_key[cur-1] == key) return cur;
      cur = node_next[cur-1];
      steps++;
    end
    return 0;
  endfunction

  // Applies one accepted item to the shadow table and returns the response due.
  function automatic rsp_item_t apply_to_index(logic op, logic [31:0] key, logic [31:0] loc);
    rsp_item_t   r;
    int unsigned node;
    logic [31:0] mag;
    int unsigned b;
    mag = key[31] ? (~key + 32'd1) : key;
    b = mag % bucket_cnt;
    node = find_key_node(key);
    r.found_location = '0;
    if (op == OP_SEARCH) begin
      if (node != 0) begin
        r.status = ST_HIT;
        r.found_location = node_loc[node-1];
      end else begin
        r.status = ST_MISS;
      end
    end else if (node != 0) begin
      node_loc[node-1] = loc;
      r.status = ST_UPDATED;
    end else if (nodes_used >= ENTRIES) begin
      r.status = ST_FULL;
    end else begin
      node_key[nodes_used] = key;
      node_loc[nodes_used] = loc;
      node_next[nodes_used] = head_of_bucket[b];
      head_of_bucket[b] = nodes_used + 1;
      nodes_used++;
      r.status = ST_INSERTED;
      if (known_keys.size() < 64) known_keys.push_back(key);
      else known_keys[$urandom_range(63)] = key;
    end
    return r;
  endfunction

  task automatic send_item(logic op, logic [31:0] key, logic [31:0] loc);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid = 1'b0;
      req_ch.opcode = $urandom;
      req_ch.key = $urandom;
      @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.opcode = op;
    req_ch.key = key;
    req_ch.location = loc;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_rsp.push_back(apply_to_index(op, key, loc));
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    bucket_cnt = (value == 0) ? 1 : (value > BUCKETS ? BUCKETS : value);
  endtask

  // Receiver side: stalls at random and checks each accepted response.
  always @(negedge clk_i) rsp_ch.ready = ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk_i) begin
    rsp_item_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3_000_000) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response: status %0d", rsp_ch.status);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status ||
            rsp_ch.found_location !== want.found_location) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, location exp %h got %h",
                     want.status, rsp_ch.status, want.found_location,
                     rsp_ch.found_location);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_SEARCH, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'd0, 32'h0000_0000);
    send_item(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_item(OP_INSERT, 32'd1, 32'h8765_4321);
    // Same magnitude, opposite signs: same bucket, different keys.
    send_item(OP_INSERT, 32'd5, 32'h0000_0005);
    send_item(OP_INSERT, -32'sd5, 32'hFFFF_FFFB);
    send_item(OP_SEARCH, 32'd5, 32'd0);
    send_item(OP_SEARCH, -32'sd5, 32'd0);
    send_item(OP_INSERT, 32'd5, 32'hDEAD_BEEF);
    send_item(OP_SEARCH, 32'd5, 32'd0);
    send_item(OP_SEARCH, 32'h8000_0000, 32'd0);
    send_item(OP_SEARCH, 32'h7FFF_FFFF, 32'd0);
    send_item(OP_SEARCH, 32'd1024, 32'd0);
    send_item(OP_SEARCH, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_SEARCH, 32'd0, 32'd0);
    drain_responses();
  endtask

  // Count written as zero, above the maximum and as small values; no rehash of old chains.
  task automatic test_bucket_count();
    logic [CNT_W-1:0] vals [4];
    vals = '{11'd0, 11'd2047, 11'd3, 11'd1};
    foreach (vals[i]) begin
      write_bucket_count(vals[i]);
      send_item(OP_SEARCH, 32'h7FFF_FFFF, 32'd0);
      send_item(OP_SEARCH, 32'd5, 32'd0);
      send_item(OP_INSERT, 32'd7 + i, 32'hC000_0000 + i);
      send_item(OP_SEARCH, 32'd7 + i, 32'd0);
      drain_responses();
    end
  endtask

  task automatic test_random(int unsigned count);
    logic        op;
    logic [31:0] key;
    int unsigned pick;
    repeat (count) begin
      op = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < 55 && known_keys.size() > 0) key = known_keys[$urandom_range(known_keys.size()-1)];
      else if (pick < 62) key = ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      else if (pick < 75) key = $urandom_range(63) - 32;
      else key = $urandom;
      send_item(op, key, $urandom);
    end
    drain_responses();
  endtask

  task automatic test_pool_full();
    int unsigned n;
    n = 0;
    while (nodes_used < ENTRIES) begin
      send_item(OP_INSERT, 32'h4000_0000 + n, $urandom);
      n++;
    end
    send_item(OP_INSERT, 32'h2000_0001, 32'h1111_1111);
    send_item(OP_SEARCH, 32'h2000_0001, 32'd0);
    send_item(OP_INSERT, 32'h4000_0000, 32'h2222_2222);
    send_item(OP_SEARCH, 32'h4000_0000, 32'd0);
    drain_responses();
  endtask

  initial begin
    foreach (head_of_bucket[i]) head_of_bucket[i] = 0;
    nodes_used = 0;
    bucket_cnt = BUCKETS;
    mismatches = 0;
    cycle_cnt = 0;
    snd_idle_pct = 12;
    rcv_idle_pct = 51;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_INSERT;
    req_ch.key = '0;
    req_ch.location = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_bucket_count();
    write_bucket_count(11'd1024);
    test_random(270);
    snd_idle_pct = 51;
    rcv_idle_pct = 12;
    write_bucket_count(11'd7);
    test_random(270);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_bucket_count(11'd1);
    test_random(270);
    write_bucket_count(11'd1024);
    test_pool_full();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/chi_pkg.sv
rtl/chi_req_if.sv
rtl/chi_rsp_if.sv
rtl/chained_hash_index_unit.sv
test/chained_hash_index_unit_tb.sv
